// ===== src/hdrp_pkg.sv =====
`default_nettype none
package hdrp_pkg;

  localparam int HEADER_BYTES   = 112;
  localparam int CRC_OFFSET     = 108;
  localparam int VERSION_OFFSET = 8;
  localparam int SIZE_OFFSET    = 16;
  localparam int DIGEST_OFFSET  = 24;

  localparam int POS_W    = 7;
  localparam int CFG_IDX_W = 8;

  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // field bounds as 8-bit constants, compared against zero-extended position
  localparam logic [7:0] MAGIC_END  = 8'd4;
  localparam logic [7:0] HVER_END   = 8'd8;
  localparam logic [7:0] CRC_LO     = 8'(CRC_OFFSET);
  localparam logic [7:0] CRC_HI     = 8'(CRC_OFFSET + 4);
  localparam logic [7:0] FWVER_LO   = 8'(VERSION_OFFSET);
  localparam logic [7:0] FWVER_HI   = 8'(VERSION_OFFSET + 8);
  localparam logic [7:0] FWSIZE_LO  = 8'(SIZE_OFFSET);
  localparam logic [7:0] FWSIZE_HI  = 8'(SIZE_OFFSET + 8);
  localparam logic [7:0] DIGEST_LO  = 8'(DIGEST_OFFSET);
  localparam logic [7:0] DIGEST_HI  = 8'(DIGEST_OFFSET + 32);
  localparam logic [7:0] LAST_POS   = 8'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] DIGEST_OFF_P = POS_W'(DIGEST_OFFSET);

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MAGIC   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_CRC_BAD = 2'd2
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [63:0]      fw_version;
    logic [63:0]      fw_size;
    logic [3:0][63:0] digest;
  } hdr_rec_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/hdrp_in_if.sv =====
`default_nettype none
interface hdrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       start_of_header;

  modport source (output valid, header_byte, start_of_header, input ready);
  modport sink (input valid, header_byte, start_of_header, output ready);
endinterface
`default_nettype wire

// ===== src/hdrp_out_if.sv =====
`default_nettype none
interface hdrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] firmware_version;
  logic [63:0] firmware_size;
  logic [63:0] digest_word;
  logic [1:0]  digest_word_index;
  logic        last_of_run;

  modport source (output valid, status, firmware_version, firmware_size, digest_word,
                  digest_word_index, last_of_run, input ready);
  modport sink (input valid, status, firmware_version, firmware_size, digest_word,
                digest_word_index, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== src/hdrp_cfg_if.sv =====
`default_nettype none
interface hdrp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/hdrp_front.sv =====
`default_nettype none
module hdrp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  hdrp_in_if.sink                hdr_in,
  hdrp_cfg_if.sink               cfg,
  input  wire logic              q_full,
  output logic                   q_push,
  output hdrp_pkg::hdr_rec_t     q_rec
);
  import hdrp_pkg::*;

  logic [31:0]      expected_magic;
  logic [31:0]      expected_version;
  logic [POS_W-1:0] byte_position;
  logic [31:0]      running_crc;
  logic [31:0]      magic_shift;
  logic [31:0]      version_shift;
  logic [31:0]      stored_crc_shift;
  logic [63:0]      fw_version_shift;
  logic [63:0]      fw_size_shift;
  logic [3:0][63:0] digest_store;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] dig_rel;
  logic [7:0]       pos8;
  logic [7:0]       b;
  logic             start;
  logic             accept;
  logic             last;
  logic [31:0]      crc_base, crc_next;
  logic [31:0]      magic_base, magic_next;
  logic [31:0]      hver_base, hver_next;
  logic [31:0]      scrc_base, scrc_next;
  logic [63:0]      fwver_base, fwver_next;
  logic [63:0]      fwsize_base, fwsize_next;
  logic [3:0][63:0] dig_base, dig_next;
  logic [31:0]      crc_final;
  status_t          status;

  assign cfg.ready    = 1'b1;
  assign hdr_in.ready = !q_full;
  assign accept       = hdr_in.valid && hdr_in.ready;
  assign b            = hdr_in.header_byte;
  assign start        = hdr_in.start_of_header;

  always_comb begin
    pos         = start ? '0 : byte_position;
    pos8        = {1'b0, pos};
    crc_base    = start ? CRC_ONES : running_crc;
    magic_base  = start ? '0 : magic_shift;
    hver_base   = start ? '0 : version_shift;
    scrc_base   = start ? '0 : stored_crc_shift;
    fwver_base  = start ? '0 : fw_version_shift;
    fwsize_base = start ? '0 : fw_size_shift;
    dig_base    = start ? '0 : digest_store;

    crc_next    = (pos8 < CRC_LO) ? crc_byte(crc_base, b) : crc_base;
    magic_next  = (pos8 < MAGIC_END) ? {magic_base[23:0], b} : magic_base;
    hver_next   = (pos8 >= MAGIC_END && pos8 < HVER_END) ? {hver_base[23:0], b} : hver_base;
    scrc_next   = (pos8 >= CRC_LO && pos8 < CRC_HI) ? {scrc_base[23:0], b} : scrc_base;
    fwver_next  = (pos8 >= FWVER_LO && pos8 < FWVER_HI) ?
                  {fwver_base[55:0], b} : fwver_base;
    fwsize_next = (pos8 >= FWSIZE_LO && pos8 < FWSIZE_HI) ?
                  {fwsize_base[55:0], b} : fwsize_base;

    dig_rel  = pos - DIGEST_OFF_P;
    dig_next = dig_base;
    if (pos8 >= DIGEST_LO && pos8 < DIGEST_HI) begin
      dig_next[dig_rel[4:3]] = {dig_base[dig_rel[4:3]][55:0], b};
    end

    last      = (pos8 == LAST_POS);
    crc_final = crc_next ^ CRC_ONES;
    if (hver_next != expected_version || magic_next != expected_magic) begin
      status = ST_INVALID;
    end else if (scrc_next != crc_final) begin
      status = ST_CRC_BAD;
    end else begin
      status = ST_OK;
    end

    q_rec.status     = status;
    q_rec.fw_version = (status == ST_OK) ? fwver_next : '0;
    q_rec.fw_size    = (status == ST_OK) ? fwsize_next : '0;
    q_rec.digest     = dig_next;
    q_push           = accept && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= '0;
      expected_version <= 32'd2;
      byte_position    <= '0;
      running_crc      <= CRC_ONES;
      magic_shift      <= '0;
      version_shift    <= '0;
      stored_crc_shift <= '0;
      fw_version_shift <= '0;
      fw_size_shift    <= '0;
      digest_store     <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_EXPECTED_MAGIC:   expected_magic   <= cfg.data;
          CFG_EXPECTED_VERSION: expected_version <= cfg.data;
          default: ;
        endcase
      end
      if (accept) begin
        if (last) begin
          // header done: rearm for the next one
          byte_position    <= '0;
          running_crc      <= CRC_ONES;
          magic_shift      <= '0;
          version_shift    <= '0;
          stored_crc_shift <= '0;
          fw_version_shift <= '0;
          fw_size_shift    <= '0;
          digest_store     <= '0;
        end else begin
          byte_position    <= pos + POS_W'(1);
          running_crc      <= crc_next;
          magic_shift      <= magic_next;
          version_shift    <= hver_next;
          stored_crc_shift <= scrc_next;
          fw_version_shift <= fwver_next;
          fw_size_shift    <= fwsize_next;
          digest_store     <= dig_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/hdrp_queue.sv =====
`default_nettype none
module hdrp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire hdrp_pkg::hdr_rec_t push_rec,
  input  wire logic               pop,
  output logic                    full,
  output logic                    empty,
  output hdrp_pkg::hdr_rec_t      head
);
  import hdrp_pkg::*;

  hdr_rec_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// ===== src/hdrp_back.sv =====
`default_nettype none
module hdrp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  wire hdrp_pkg::hdr_rec_t q_head,
  output logic                    q_pop,
  hdrp_out_if.source              res_out
);
  import hdrp_pkg::*;

  logic [1:0]  word_cnt;
  logic        load;
  logic        valid;
  logic [1:0]  status;
  logic [63:0] firmware_version;
  logic [63:0] firmware_size;
  logic [63:0] digest_word;
  logic [1:0]  digest_word_index;
  logic        last_of_run;

  // output register refills in the same cycle it drains
  assign load  = !q_empty && (!valid || res_out.ready);
  assign q_pop = load && (word_cnt == 2'd3);

  assign res_out.valid             = valid;
  assign res_out.status            = status;
  assign res_out.firmware_version  = firmware_version;
  assign res_out.firmware_size     = firmware_size;
  assign res_out.digest_word       = digest_word;
  assign res_out.digest_word_index = digest_word_index;
  assign res_out.last_of_run       = last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      word_cnt <= '0;
    end else if (load) begin
      valid    <= 1'b1;
      word_cnt <= word_cnt + 2'd1;
    end else if (res_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status            <= q_head.status;
      firmware_version  <= q_head.fw_version;
      firmware_size     <= q_head.fw_size;
      digest_word       <= q_head.digest[word_cnt];
      digest_word_index <= word_cnt;
      last_of_run       <= (word_cnt == 2'd3);
    end
  end

endmodule
`default_nettype wire

// ===== src/image_header_parse_crc_check_core.sv =====
// Firmware image header parser with CRC-32 check.
// hdr_in: one header byte per transaction, start_of_header marks byte 0 and
//   abandons any header in progress. Bytes are taken at one per cycle while the front/back queue is not full.
// cfg: register writes (index 0 expected magic, index 1 expected header
//   version), always ready; write only while the block is idle.
// res_out: four transactions per header, one per 64-bit digest word, the
//   last flagged by last_of_run. Status, version and size repeat on all four.
// Results: after the last header byte is taken, its record is written into
//   the front/back queue and from there loaded into the output register;
//   the four results then go out one per cycle while the receiver is ready.
// Throughput: one byte per cycle, set by the combinational CRC and field
//   capture in the front. A two-entry queue of finished headers lets the
//   front keep taking bytes while results drain; hdr_in.ready drops only
//   when both entries are full behind a stalled receiver.
// Reset: registers return to magic 0 and version 2, the byte position and
//   CRC rearm, the queue and output register empty.
`default_nettype none
module image_header_parse_crc_check_core (
  input  wire logic clk,
  input  wire logic rst,
  hdrp_in_if.sink     hdr_in,
  hdrp_cfg_if.sink    cfg,
  hdrp_out_if.source  res_out
);
  import hdrp_pkg::*;

  hdr_rec_t push_rec;
  hdr_rec_t head;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  hdrp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .hdr_in (hdr_in),
    .cfg    (cfg),
    .q_full (full),
    .q_push (push),
    .q_rec  (push_rec)
  );

  hdrp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  hdrp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (empty),
    .q_head  (head),
    .q_pop   (pop),
    .res_out (res_out)
  );

endmodule
`default_nettype wire

// ===== src/hdrp_checker.sv =====
`default_nettype none
module hdrp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [63:0] firmware_version,
  input wire logic [63:0] firmware_size,
  input wire logic [1:0]  digest_word_index,
  input wire logic        last_of_run
);
  import hdrp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word_index))
    else $error("result dropped while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_of_run == (digest_word_index == 2'd3)))
    else $error("last_of_run not on the fourth word");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> firmware_version == '0 && firmware_size == '0)
    else $error("version or size leaked on failed header");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run ##1 out_valid |->
      digest_word_index == $past(digest_word_index) + 2'd1)
    else $error("digest words out of order");

  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind image_header_parse_crc_check_core hdrp_checker u_hdrp_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (res_out.valid),
  .out_ready         (res_out.ready),
  .status            (res_out.status),
  .firmware_version  (res_out.firmware_version),
  .firmware_size     (res_out.firmware_size),
  .digest_word_index (res_out.digest_word_index),
  .last_of_run       (res_out.last_of_run)
);
`default_nettype wire

// ===== dv/tb_image_header_parse_crc_check_core.sv =====
`timescale 1ns / 1ps
module tb_image_header_parse_crc_check_core;
  import hdrp_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       sof;
  } hdr_byte_t;

  typedef struct {
    status_t     status;
    logic [63:0] fw_version;
    logic [63:0] fw_size;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last;
  } header_result_t;

  typedef enum {HDR_GOOD, HDR_BAD_MAGIC, HDR_BAD_VERSION, HDR_BAD_CRC} hdr_kind_e;
  typedef enum {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_e;

  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int MAX_SHOWN        = 10;

  logic clk;
  logic rst;

  hdrp_in_if  hdr_if ();
  hdrp_cfg_if cfg_if ();
  hdrp_out_if res_if ();

  image_header_parse_crc_check_core u_top (
    .clk     (clk),
    .rst     (rst),
    .hdr_in  (hdr_if),
    .cfg     (cfg_if),
    .res_out (res_if)
  );

  // header parse state tracked alongside the block
  logic [POS_W-1:0] hp_pos;
  logic [31:0]      hp_crc;
  logic [31:0]      hp_magic;
  logic [31:0]      hp_hver;
  logic [31:0]      hp_stored_crc;
  logic [63:0]      hp_fw_version;
  logic [63:0]      hp_fw_size;
  logic [63:0]      hp_digest [4];
  logic [31:0]      model_magic;
  logic [31:0]      model_hver;

  header_result_t due_results[$];
  hdr_byte_t      outgoing_bytes[$];
  hdr_byte_t      drv_item;

  logic [31:0] stim_magic;
  logic [31:0] stim_hver;
  bit          armed;
  bit          idling_on;
  bit          hold_request;
  logic        in_fire_q;
  int          src_gap;
  int          sink_gap;
  int          long_hold_left;
  int          err_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc;
    // bit-serial, LSB first (reflected)
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic clear_parse_state();
    hp_pos        = '0;
    hp_crc        = CRC_ONES;
    hp_magic      = '0;
    hp_hver       = '0;
    hp_stored_crc = '0;
    hp_fw_version = '0;
    hp_fw_size    = '0;
    for (int k = 0; k < 4; k++) hp_digest[k] = '0;
  endtask

  task automatic parse_header_byte(input logic [7:0] b, input logic sof);
    logic [1:0]     w;
    status_t        st;
    header_result_t r;
    if (sof) clear_parse_state();
    if (hp_pos < CRC_OFFSET) hp_crc = crc32_update(hp_crc, b);
    if (hp_pos < 4) hp_magic = {hp_magic[23:0], b};
    if (hp_pos >= 4 && hp_pos < 8) hp_hver = {hp_hver[23:0], b};
    if (hp_pos >= CRC_OFFSET && hp_pos < CRC_OFFSET + 4)
      hp_stored_crc = {hp_stored_crc[23:0], b};
    if (hp_pos >= VERSION_OFFSET && hp_pos < VERSION_OFFSET + 8)
      hp_fw_version = {hp_fw_version[55:0], b};
    if (hp_pos >= SIZE_OFFSET && hp_pos < SIZE_OFFSET + 8)
      hp_fw_size = {hp_fw_size[55:0], b};
    if (hp_pos >= DIGEST_OFFSET && hp_pos < DIGEST_OFFSET + 32) begin
      w = 2'((int'(hp_pos) - DIGEST_OFFSET) >> 3);
      hp_digest[w] = {hp_digest[w][55:0], b};
    end
    if (hp_pos != HEADER_BYTES - 1) begin
      hp_pos = hp_pos + 1'b1;
    end else begin
      if (hp_hver != model_hver || hp_magic != model_magic) st = ST_INVALID;
      else if (hp_stored_crc != (hp_crc ^ CRC_ONES)) st = ST_CRC_BAD;
      else st = ST_OK;
      for (int k = 0; k < 4; k++) begin
        r.status      = st;
        r.fw_version  = (st == ST_OK) ? hp_fw_version : 64'd0;
        r.fw_size     = (st == ST_OK) ? hp_fw_size : 64'd0;
        r.digest_word = hp_digest[k];
        r.word_index  = 2'(k);
        r.last        = (k == 3);
        due_results.push_back(r);
      end
      clear_parse_state();
    end
  endtask

  task automatic check_result();
    header_result_t want;
    if (due_results.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_SHOWN)
        $display("%0t: unexpected result st=%0d idx=%0d dig=%h", $time,
                 res_if.status, res_if.digest_word_index, res_if.digest_word);
    end else begin
      want = due_results.pop_front();
      if (res_if.status !== want.status || res_if.firmware_version !== want.fw_version ||
          res_if.firmware_size !== want.fw_size || res_if.digest_word !== want.digest_word ||
          res_if.digest_word_index !== want.word_index || res_if.last_of_run !== want.last)
      begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN) begin
          $display("%0t: mismatch exp st=%0d ver=%h size=%h dig=%h idx=%0d last=%0b",
                   $time, want.status, want.fw_version, want.fw_size, want.digest_word,
                   want.word_index, want.last);
          $display("%0t:          got st=%0d ver=%h size=%h dig=%h idx=%0d last=%0b",
                   $time, res_if.status, res_if.firmware_version, res_if.firmware_size,
                   res_if.digest_word, res_if.digest_word_index, res_if.last_of_run);
        end
      end
    end
  endtask

  // monitor: register writes, accepted bytes, then results
  always @(posedge clk) begin
    if (rst) begin
      in_fire_q   <= 1'b0;
      model_magic = '0;
      model_hver  = 32'd2;
      clear_parse_state();
    end else begin
      in_fire_q <= hdr_if.valid && hdr_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_EXPECTED_MAGIC:   model_magic = cfg_if.data;
          CFG_EXPECTED_VERSION: model_hver  = cfg_if.data;
          default: ;
        endcase
      end
      if (hdr_if.valid && hdr_if.ready)
        parse_header_byte(hdr_if.header_byte, hdr_if.start_of_header);
      if (res_if.valid && res_if.ready) check_result();
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      hdr_if.valid <= 1'b0;
    end else if (!hdr_if.valid || in_fire_q) begin
      if (src_gap > 0) begin
        src_gap--;
        hdr_if.valid <= 1'b0;
      end else if (outgoing_bytes.size() != 0) begin
        drv_item = outgoing_bytes.pop_front();
        hdr_if.valid           <= 1'b1;
        hdr_if.header_byte     <= drv_item.b;
        hdr_if.start_of_header <= drv_item.sof;
        if (idling_on && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 11);
      end else begin
        hdr_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request   = 1'b0;
      long_hold_left = LONG_HOLD_CYCLES;
    end
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      res_if.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      if (idling_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 11);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_EXPECTED_MAGIC) stim_magic = val;
    else stim_hver = val;
  endtask

  task automatic wait_idle();
    while (outgoing_bytes.size() != 0 || hdr_if.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // keep < HEADER_BYTES gives a truncated header (abandoned by the next start flag)
  task automatic queue_header(input hdr_kind_e kind, input fill_e fill, input logic lead_sof,
                              input int keep);
    logic [7:0]  img [HEADER_BYTES];
    logic [31:0] crc;
    logic [31:0] magic_v;
    logic [31:0] hver_v;
    hdr_byte_t   item;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      case (fill)
        FILL_ZEROS: img[i] = 8'h00;
        FILL_ONES:  img[i] = 8'hFF;
        default:    img[i] = 8'($urandom);
      endcase
    end
    magic_v = stim_magic;
    hver_v  = stim_hver;
    if (kind == HDR_BAD_MAGIC) magic_v ^= 32'h1 << $urandom_range(0, 31);
    if (kind == HDR_BAD_VERSION) hver_v ^= 32'h1 << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) begin
      img[i]     = magic_v[31-8*i -: 8];
      img[4 + i] = hver_v[31-8*i -: 8];
    end
    crc = CRC_ONES;
    for (int i = 0; i < CRC_OFFSET; i++) crc = crc32_update(crc, img[i]);
    crc ^= CRC_ONES;
    if (kind == HDR_BAD_CRC) crc ^= 32'h1 << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) img[CRC_OFFSET + i] = crc[31-8*i -: 8];
    for (int i = 0; i < keep; i++) begin
      item.b   = img[i];
      item.sof = (i == 0) ? lead_sof : 1'b0;
      outgoing_bytes.push_back(item);
    end
  endtask

  task automatic queue_noise(input int len);
    hdr_byte_t item;
    repeat (len) begin
      item.b   = 8'($urandom);
      item.sof = ($urandom_range(0, 15) == 0);
      outgoing_bytes.push_back(item);
    end
  endtask

  // mostly well-formed headers, some broken ones and noise
  task automatic queue_random_traffic(input int n);
    int unsigned pick;
    logic        sof;
    armed = 1'b0;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      sof  = armed ? 1'($urandom_range(0, 1)) : 1'b1;
      if (pick < 2) begin
        queue_noise($urandom_range(1, 40));
        armed = 1'b0;
      end else if (pick < 4) begin
        queue_header(HDR_GOOD, FILL_RANDOM, 1'b1, $urandom_range(1, HEADER_BYTES - 1));
        armed = 1'b0;
      end else begin
        if (pick < 6) queue_header(HDR_BAD_CRC, FILL_RANDOM, sof, HEADER_BYTES);
        else if (pick == 6) queue_header(HDR_BAD_MAGIC, FILL_RANDOM, sof, HEADER_BYTES);
        else if (pick == 7) queue_header(HDR_BAD_VERSION, FILL_RANDOM, sof, HEADER_BYTES);
        else queue_header(HDR_GOOD, FILL_RANDOM, sof, HEADER_BYTES);
        armed = 1'b1;
      end
    end
  endtask

  initial begin
    rst                    = 1'b1;
    hdr_if.valid           = 1'b0;
    hdr_if.header_byte     = '0;
    hdr_if.start_of_header = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = '0;
    cfg_if.data            = '0;
    res_if.ready           = 1'b0;
    stim_magic             = '0;
    stim_hver              = 32'd2;
    idling_on              = 1'b1;
    hold_request           = 1'b0;
    src_gap                = 0;
    sink_gap               = 0;
    long_hold_left         = 0;
    err_cnt                = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values; every status, rearm without start flag, restarts
    queue_header(HDR_GOOD, FILL_ZEROS, 1'b1, HEADER_BYTES);
    queue_header(HDR_GOOD, FILL_ONES, 1'b0, HEADER_BYTES);
    queue_header(HDR_BAD_MAGIC, FILL_RANDOM, 1'b1, HEADER_BYTES);
    queue_header(HDR_BAD_VERSION, FILL_RANDOM, 1'b0, HEADER_BYTES);
    queue_header(HDR_BAD_CRC, FILL_RANDOM, 1'b1, HEADER_BYTES);
    queue_header(HDR_GOOD, FILL_RANDOM, 1'b1, 50);
    queue_header(HDR_GOOD, FILL_RANDOM, 1'b1, HEADER_BYTES);
    queue_header(HDR_GOOD, FILL_ONES, 1'b1, HEADER_BYTES - 1);
    queue_header(HDR_GOOD, FILL_ZEROS, 1'b1, HEADER_BYTES);
    wait_idle();

    write_reg(CFG_EXPECTED_MAGIC, 32'hFFFF_FFFF);
    write_reg(CFG_EXPECTED_VERSION, 32'h0000_0000);
    queue_header(HDR_GOOD, FILL_ONES, 1'b1, HEADER_BYTES);
    queue_header(HDR_GOOD, FILL_ZEROS, 1'b0, HEADER_BYTES);
    queue_header(HDR_BAD_CRC, FILL_ONES, 1'b1, HEADER_BYTES);
    queue_header(HDR_BAD_VERSION, FILL_ZEROS, 1'b0, HEADER_BYTES);
    queue_header(HDR_GOOD, FILL_RANDOM, 1'b0, HEADER_BYTES);
    wait_idle();

    // receiver stalls long enough for the block to back up its input
    write_reg(CFG_EXPECTED_MAGIC, $urandom);
    write_reg(CFG_EXPECTED_VERSION, 32'hFFFF_FFFF);
    queue_random_traffic(12);
    @(posedge clk);
    hold_request = 1'b1;
    wait_idle();

    write_reg(CFG_EXPECTED_MAGIC, $urandom);
    write_reg(CFG_EXPECTED_VERSION, $urandom);
    queue_random_traffic(10);
    wait_idle();

    idling_on = 1'b0;
    write_reg(CFG_EXPECTED_MAGIC, 32'h0000_0000);
    write_reg(CFG_EXPECTED_VERSION, 32'd2);
    queue_random_traffic(6);
    wait_idle();

    if (due_results.size() != 0) err_cnt++;
    if (err_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hdrp_pkg.sv
src/hdrp_in_if.sv
src/hdrp_out_if.sv
src/hdrp_cfg_if.sv
src/hdrp_front.sv
src/hdrp_queue.sv
src/hdrp_back.sv
src/image_header_parse_crc_check_core.sv
src/hdrp_checker.sv
dv/tb_image_header_parse_crc_check_core.sv
